// ----- design/mfd_pkg.sv -----
// Package for the modulated feedback delay: shared constants, register
// indexes and the 24-bit saturation helper.
// No dependencies.
package mfd_pkg;

  localparam int DelayDepthDef   = 65536;
  localparam int UpdateIntDef    = 100;
  localparam int SineDepthDef    = 256;

  // Divider operand widths (dividend is up to |t| * 2^23 of the limiter)
  localparam int DivnW = 52;
  localparam int DivdW = 32;

  // Target smoothing divisor, done as a reciprocal multiplication
  localparam int SmoothDiv = 100;
  localparam int SmoothSh  = 32 + $clog2(SmoothDiv);
  localparam logic [32:0] SmoothRecip =
    33'(((64'd1 << SmoothSh) + 64'(SmoothDiv) - 64'd1) / 64'(SmoothDiv));

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDelay   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegModDep  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLfoStep = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFbGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTone    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLowMix  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWet     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDry     = 3'd7;

  // Limiter release factors, Q0.24
  localparam logic [23:0] RelLimit = 24'd13421773;
  localparam logic [23:0] RelSat   = 24'd16772183;

  localparam logic [31:0] OneQ23 = 32'd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = 24'sh7FFFFF;
    else if (v < -48'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ----- design/mfd_ram.sv -----
// Delay line storage: one write port, one read port, registered read data.
// Depends on nothing.
module mfd_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int W     = 24
) (
  input  logic         clk,
  input  logic         we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mfd_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, 32 quotient bits.
// Depends on mfd_pkg. The upper dividend bits must stay below the divisor.
module mfd_div
  import mfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DivnW-1:0] dividend,
  input  logic [DivdW-1:0] divisor,
  output logic             done,
  output logic [DivdW-1:0] quotient
);

  logic [DivdW:0]   rem;
  logic [DivdW-1:0] low;
  logic [DivdW:0]   div_r;
  logic [5:0]       cnt;
  logic             busy;
  logic [DivdW:0]   rem_sh;
  logic             ge;

  assign rem_sh   = {rem[DivdW-1:0], low[DivdW-1]};
  assign ge       = rem_sh >= div_r;
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= (DivdW+1)'(dividend[DivnW-1:DivdW]);
        low   <= dividend[DivdW-1:0];
        div_r <= {1'b0, divisor};
        cnt   <= 6'd32;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rem_sh - div_r : rem_sh;
        low <= {low[DivdW-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/modulated_feedback_delay_top.sv -----
// Modulated feedback delay, top level: registers, sequencer and datapath.
// Depends on mfd_pkg, mfd_ram and mfd_div.
//
// Usage: one request on in_valid/in_ready carries a Q1.23 sample in
// in_sample; exactly one result leaves on out_valid/out_ready in
// out_sample. One sample is worked on at a time: in_ready is high only
// while the sequencer is idle.
// in_ready returns in the same cycle as out_valid. When the envelope
// exceeds full scale, the sequencer also waits for the limiter division.
// Every UPDATE_INTERVAL samples the delay smoothing update adds a sine
// polynomial and two reciprocal multiplications for the constant
// divisions. The bit-serial limiter divider and the single read port of
// the delay memory (two reads per sample) set the pace of the sequencer.
// Reset: all control state and registers return to their defaults, then
// a clearing pass writes zero into every delay line entry, one per cycle,
// while in_ready stays low. Configuration writes are taken at any time,
// and should be made only while idle.
// Stall: a finished result waits in the output register; the sequencer
// holds at its last step until that register is free, so no result is
// dropped while out_ready is low.
module modulated_feedback_delay_top
  import mfd_pkg::*;
#(
  parameter int DELAY_DEPTH      = DelayDepthDef,
  parameter int UPDATE_INTERVAL  = UpdateIntDef,
  parameter int SINE_TABLE_DEPTH = SineDepthDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgDataW-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [23:0]        in_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [23:0]        out_sample
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int CW  = $clog2(UPDATE_INTERVAL + 1);
  localparam int LSD = $clog2(SINE_TABLE_DEPTH);
  localparam logic [15:0] PhMask = 16'(16'hFFFF << (16 - LSD));
  localparam logic [AW-1:0] WpLast = AW'(DELAY_DEPTH - 1);
  localparam logic signed [33:0] DMax = (34'(DELAY_DEPTH) <<< 12) - 34'sd1;
  localparam logic [20:0] BaseMax = 21'(DELAY_DEPTH - 1);
  localparam int IncSh = 32 + $clog2(UPDATE_INTERVAL);
  localparam logic [32:0] IncRecip =
    33'(((64'd1 << IncSh) + 64'(UPDATE_INTERVAL) - 64'd1) / 64'(UPDATE_INTERVAL));

  typedef enum logic [4:0] {
    S_IDLE, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_SIN5, S_MOD, S_DIFF, S_DIV1,
    S_TGT, S_INC, S_DIV2, S_STEP, S_ADV, S_ADDR, S_RD2, S_RD3, S_RD4, S_DLY,
    S_FB, S_LP, S_MIXA, S_MIXB, S_ENV, S_LIMW, S_WR, S_OUT1, S_OUT2
  } state_t;

  // Configuration registers
  logic [15:0]        delay_samples;
  logic [19:0]        mod_depth;
  logic [13:0]        lfo_step;
  logic signed [15:0] feedback_gain;
  logic [15:0]        tone_coeff;
  logic signed [15:0] low_mix;
  logic [14:0]        wet_gain;
  logic [15:0]        dry_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= 16'd24000;
      mod_depth     <= 20'd0;
      lfo_step      <= 14'd410;
      feedback_gain <= 16'sd7209;
      tone_coeff    <= 16'd62000;
      low_mix       <= 16'sd3277;
      wet_gain      <= 15'd3619;
      dry_gain      <= 16'd14600;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDelay:   delay_samples <= cfg_data[15:0];
        RegModDep:  mod_depth     <= cfg_data;
        RegLfoStep: lfo_step      <= cfg_data[13:0];
        RegFbGain:  feedback_gain <= cfg_data[15:0];
        RegTone:    tone_coeff    <= cfg_data[15:0];
        RegLowMix:  low_mix       <= cfg_data[15:0];
        RegWet:     wet_gain      <= cfg_data[14:0];
        RegDry:     dry_gain      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers
  state_t             state;
  logic               clearing;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      wp;
  logic signed [31:0] target_delay;
  logic signed [31:0] current_delay;
  logic signed [31:0] delay_increment;
  logic [CW-1:0]      countdown;
  logic [15:0]        lfo_phase;
  logic signed [31:0] lowpass_state;
  logic [31:0]        envelope;

  logic signed [23:0] x_r;
  logic [1:0]         quad;
  logic [14:0]        z_r;
  logic [14:0]        z2_r;
  logic [14:0]        r_r;
  logic signed [15:0] s_r;
  logic signed [25:0] ms_r;
  logic               neg_r;
  logic [31:0]        rcp_m;
  logic [31:0]        q_r;
  logic [AW-1:0]      i2_r;
  logic [11:0]        frac_r;
  logic signed [23:0] a_r;
  logic signed [37:0] pint_r;
  logic signed [25:0] delayed;
  logic signed [31:0] t1;
  logic signed [47:0] pa_r;
  logic signed [31:0] t2;
  logic signed [31:0] t_fin;
  logic signed [40:0] pdry_r;

  logic               div_start;
  logic [DivnW-1:0]   div_dividend;
  logic [DivdW-1:0]   div_divisor;
  logic               div_done;
  logic [DivdW-1:0]   div_q;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [23:0]        mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [23:0]        mem_rdata;

  // Combinational helpers
  logic [15:0]        ph;
  logic [14:0]        s_mag;
  logic signed [40:0] pmod;
  logic [20:0]        base;
  logic signed [33:0] diff;
  logic signed [32:0] inc_diff;
  logic [32:0]        rcp_k;
  logic [64:0]        rcp_prod;
  logic signed [33:0] dclamp;
  logic [AW:0]        i1_sum;
  logic [AW-1:0]      i1;
  logic [16:0]        fbmag;
  logic signed [16:0] hmix;
  logic signed [44:0] pfb;
  logic signed [49:0] plp;
  logic signed [48:0] pb;
  logic [55:0]        env_dec;
  logic [31:0]        g;
  logic [31:0]        env_n;
  logic signed [41:0] pwet;
  logic signed [42:0] osum;

  assign ph    = lfo_phase & PhMask;
  assign s_mag = 15'((30'(z_r) * 30'(r_r)) >> 14);
  assign pmod  = 41'($signed({1'b0, mod_depth, 4'b0})) * 41'(s_r);
  assign base  = (21'(delay_samples) > BaseMax) ? BaseMax : 21'(delay_samples);
  assign diff  = 34'($signed({1'b0, base, 12'b0})) - 34'(target_delay)
               - 34'($signed({1'b0, mod_depth, 4'b0})) - 34'(ms_r);
  assign inc_diff = 33'(target_delay) - 33'(current_delay);

  // Divide a magnitude by a constant: multiply by its scaled reciprocal
  assign rcp_k    = (state == S_DIV2) ? IncRecip : SmoothRecip;
  assign rcp_prod = 65'(rcp_m) * 65'(rcp_k);

  assign dclamp = (current_delay < 0) ? 34'sd0 :
                  ((34'(current_delay) > DMax) ? DMax : 34'(current_delay));
  assign i1_sum = (AW+1)'(wp) + (AW+1)'(dclamp[12+AW-1:12]);
  assign i1     = (i1_sum >= (AW+1)'(DELAY_DEPTH)) ?
                  AW'(i1_sum - (AW+1)'(DELAY_DEPTH)) : i1_sum[AW-1:0];

  assign fbmag = (feedback_gain < 0) ? 17'(-18'(feedback_gain)) : 17'(feedback_gain);
  assign hmix  = (low_mix < 0) ? 17'sd16384 : 17'sd16384 - 17'(low_mix);
  assign pfb   = 45'($signed({1'b0, fbmag})) * 45'(delayed);
  assign plp   = 50'(lowpass_state - t1) * 50'($signed({1'b0, tone_coeff}));
  assign pb    = 49'(hmix) * 49'(t1);
  assign env_dec = 56'(envelope) * 56'((feedback_gain > 0) ? RelLimit : RelSat);
  assign g     = (t2 < 0) ? 32'(-t2) : 32'(t2);
  assign env_n = (g > 32'(env_dec >> 24)) ? g : 32'(env_dec >> 24);
  assign pwet  = 42'($signed({1'b0, wet_gain})) * 42'(delayed);
  assign osum  = 43'(pdry_r) + 43'(pwet);

  assign in_ready = (state == S_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clearing        <= 1'b1;
      clr_addr        <= '0;
      wp              <= '0;
      target_delay    <= '0;
      current_delay   <= '0;
      delay_increment <= '0;
      countdown       <= '0;
      lfo_phase       <= '0;
      lowpass_state   <= '0;
      envelope        <= '0;
      out_valid       <= 1'b0;
      div_start       <= 1'b0;
    end else begin
      // start the limiter division when the envelope passes full scale
      div_start <= (state == S_ENV) && (env_n > OneQ23);
      if (out_valid && out_ready && state != S_OUT2) begin
        out_valid <= 1'b0;
      end
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == WpLast) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x_r   <= in_sample;
            state <= (countdown == '0) ? S_SIN1 : S_ADV;
          end
        end
        // Sine of the quantised lfo phase
        S_SIN1: begin
          quad  <= ph[15:14];
          z_r   <= ph[14] ? 15'(15'd16384 - 15'(ph[13:0])) : 15'(ph[13:0]);
          state <= S_SIN2;
        end
        S_SIN2: begin
          z2_r  <= 15'((30'(z_r) * 30'(z_r)) >> 14);
          state <= S_SIN3;
        end
        S_SIN3: begin
          r_r   <= 15'd10584 - 15'((26'(z2_r) * 26'd1306) >> 14);
          state <= S_SIN4;
        end
        S_SIN4: begin
          r_r   <= 15'd25736 - 15'((30'(z2_r) * 30'(r_r)) >> 14);
          state <= S_SIN5;
        end
        S_SIN5: begin
          if (s_mag > 15'd16384) begin
            s_r <= quad[1] ? -16'sd16384 : 16'sd16384;
          end else begin
            s_r <= quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
          end
          state <= S_MOD;
        end
        S_MOD: begin
          ms_r  <= 26'(pmod >>> 14);
          state <= S_DIFF;
        end
        // Smooth the target towards the modulated delay
        S_DIFF: begin
          neg_r <= diff < 0;
          rcp_m <= 32'((diff < 0) ? -diff : diff);
          state <= S_DIV1;
        end
        S_DIV1: begin
          q_r   <= 32'(rcp_prod >> SmoothSh);
          state <= S_TGT;
        end
        S_TGT: begin
          target_delay <= target_delay + (neg_r ? -$signed(q_r) : $signed(q_r));
          state        <= S_INC;
        end
        // divide the step to the new target over one interval
        S_INC: begin
          neg_r <= inc_diff < 0;
          rcp_m <= 32'((inc_diff < 0) ? -inc_diff : inc_diff);
          state <= S_DIV2;
        end
        S_DIV2: begin
          q_r   <= 32'(rcp_prod >> IncSh);
          state <= S_STEP;
        end
        S_STEP: begin
          delay_increment <= neg_r ? -$signed(q_r) : $signed(q_r);
          lfo_phase       <= lfo_phase + 16'(lfo_step);
          countdown       <= CW'(UPDATE_INTERVAL);
          state           <= S_ADV;
        end
        // Advance the per-sample state
        S_ADV: begin
          countdown     <= countdown - CW'(1);
          current_delay <= current_delay + delay_increment;
          wp            <= (wp == '0) ? WpLast : wp - AW'(1);
          state         <= S_ADDR;
        end
        S_ADDR: begin
          frac_r <= dclamp[11:0];
          i2_r   <= (i1 == WpLast) ? '0 : i1 + AW'(1);
          state  <= S_RD2;
        end
        S_RD2: begin
          a_r   <= mem_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          state <= S_RD4;
        end
        S_RD4: begin
          pint_r <= 38'(25'($signed(mem_rdata)) - 25'(a_r)) * 38'($signed({1'b0, frac_r}));
          state  <= S_DLY;
        end
        S_DLY: begin
          delayed <= 26'(a_r) + 26'(pint_r >>> 12);
          state   <= S_FB;
        end
        S_FB: begin
          t1    <= 32'(x_r) + 32'(pfb >>> 14);
          state <= S_LP;
        end
        S_LP: begin
          lowpass_state <= t1 + 32'(plp >>> 16);
          state         <= S_MIXA;
        end
        S_MIXA: begin
          pa_r  <= 48'(low_mix) * 48'(lowpass_state);
          state <= S_MIXB;
        end
        S_MIXB: begin
          t2    <= 32'((49'(pa_r) + pb) >>> 14);
          state <= S_ENV;
        end
        // Peak limiter
        S_ENV: begin
          envelope <= env_n;
          if (env_n > OneQ23) begin
            neg_r        <= t2 < 0;
            div_dividend <= {g[28:0], 23'b0};
            div_divisor  <= env_n;
            state        <= S_LIMW;
          end else begin
            t_fin <= t2;
            state <= S_WR;
          end
        end
        S_LIMW: begin
          if (div_done) begin
            t_fin <= neg_r ? -$signed(div_q) : $signed(div_q);
            state <= S_WR;
          end
        end
        S_WR: begin
          state <= S_OUT1;
        end
        S_OUT1: begin
          pdry_r <= 41'($signed({1'b0, dry_gain})) * 41'(x_r);
          state  <= S_OUT2;
        end
        S_OUT2: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_sample <= sat24(48'(osum >>> 14));
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    mem_we    = clearing || (state == S_WR);
    mem_waddr = clearing ? clr_addr : wp;
    mem_wdata = clearing ? 24'd0 : sat24(48'(t_fin));
    mem_raddr = (state == S_ADDR) ? i1 : i2_r;
  end

  mfd_ram #(
    .DEPTH(DELAY_DEPTH),
    .AW   (AW),
    .W    (24)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mfd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

// ----- design/mfd_checker.sv -----
// Port-level checks for the modulated feedback delay top level.
// Depends on modulated_feedback_delay_top; attached by bind below.
module mfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_sample
);

  // A waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output changed while stalled");

  // One request at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // A result never appears in the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind modulated_feedback_delay_top mfd_checker u_mfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_sample(out_sample)
);

// ----- verif/tb.sv -----
// Self-checking bench for modulated_feedback_delay_top: a bit-exact software
// model of the modulated delay, tone stage and limiter predicts every output.
// Depends on mfd_pkg and the design under design/.

// Holds its own copy of the delay line, smoothing state and registers, and
// queues the expected output for every accepted request.
class echo_scoreboard;
  int unsigned regs [8];
  int unsigned reg_w [8] = '{16, 20, 14, 16, 16, 16, 15, 16};
  int          echo_mem [65536];
  int          wr_pos;
  longint      tgt_dly, cur_dly, dly_step;
  int          countdown, lfo_ph;
  longint      lp_acc;
  longint      env;
  logic signed [23:0] expected_out [$];
  int          mismatches, checked;

  function new();
    regs = '{24000, 0, 410, 7209, 62000, 3277, 3619, 14600};
    foreach (echo_mem[k]) echo_mem[k] = 0;
    wr_pos = 0; tgt_dly = 0; cur_dly = 0; dly_step = 0;
    countdown = 0; lfo_ph = 0; lp_acc = 0; env = 0;
    mismatches = 0; checked = 0;
  endfunction

  function void set_reg(int idx, int unsigned val);
    regs[idx] = val & ((32'd1 << reg_w[idx]) - 1);
  endfunction

  function longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function longint sext16(int unsigned v);
    return longint'(signed'(v[15:0]));
  endfunction

  // Polynomial sine, Q14, on the phase quantised to the table depth
  function longint lfo_sine(int ph16);
    int q, ph, quad, w, z, z2, r, s;
    q = (ph16 * 256) >> 16;
    ph = ((q << 16) / 256) & 65535;
    quad = ph >> 14;
    w = ph & 16383;
    z = (quad & 1) ? 16384 - w : w;
    z2 = (z * z) >> 14;
    r = 10584 - ((z2 * 1306) >> 14);
    r = 25736 - ((z2 * r) >> 14);
    s = (z * r) >> 14;
    if (s > 16384) s = 16384;
    return (quad >= 2) ? -longint'(s) : longint'(s);
  endfunction

  function void note_sample(logic signed [23:0] smp);
    longint x, fb, lmix, hmix, fbmag, rel, base, modv, diff, d, n, fr;
    longint a, b, dly, t, g, ev;
    int i1, i2;
    x = longint'(smp);
    fb = sext16(regs[3]);
    lmix = sext16(regs[5]);
    hmix = (lmix < 0) ? 16384 : 16384 - lmix;
    fbmag = (fb < 0) ? -fb : fb;
    rel = (fb > 0) ? 13421773 : 16772183;

    if (countdown == 0) begin
      base = regs[0];
      if (base > 65535) base = 65535;
      modv = longint'(regs[1]) << 4;
      diff = (base << 12) - tgt_dly - modv - ((modv * lfo_sine(lfo_ph)) >>> 14);
      tgt_dly += diff / 100;
      dly_step = (tgt_dly - cur_dly) / 100;
      lfo_ph = (lfo_ph + regs[2]) & 65535;
      countdown = 100;
    end
    countdown--;
    cur_dly += dly_step;
    wr_pos = (wr_pos == 0) ? 65535 : wr_pos - 1;

    // clamp the read delay into the line, then interpolate
    d = cur_dly;
    if (d < 0) d = 0;
    if (d > (longint'(65536) << 12) - 1) d = (longint'(65536) << 12) - 1;
    n = d >> 12;
    fr = d & 4095;
    i1 = (wr_pos + n) % 65536;
    i2 = (i1 + 1) % 65536;
    a = echo_mem[i1];
    b = echo_mem[i2];
    dly = a + (((b - a) * fr) >>> 12);

    t = x + ((fbmag * dly) >>> 14);
    lp_acc = t + (((lp_acc - t) * longint'(regs[4])) >>> 16);
    t = (lmix * lp_acc + hmix * t) >>> 14;

    g = (t < 0) ? -t : t;
    ev = (env * rel) >> 24;
    if (g > ev) ev = g;
    env = ev & 64'hFFFF_FFFF;
    if (ev > 8388608) t = (t * 8388608) / ev;
    echo_mem[wr_pos] = int'(clip24(t));

    t = (longint'(regs[7]) * x + longint'(regs[6]) * dly) >>> 14;
    expected_out.push_back(24'(clip24(t)));
  endfunction

  function void check_output(logic signed [23:0] got);
    logic signed [23:0] want;
    checked++;
    if (expected_out.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output sample %0d", got);
      return;
    end
    want = expected_out.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("out_sample mismatch at output %0d: expected %0d, got %0d",
                 checked, want, got);
    end
  endfunction
endclass

module tb;
  import mfd_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [23:0]  in_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [23:0]  out_sample;

  echo_scoreboard sb = new();

  // receiver controls: stall pattern, plus one long hold-off on request
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   rx_mode = 0;
  int   rx_left = 0;
  int   burst_left = 0;
  int   sent = 0;

  // Register settings per phase, in register index order
  int unsigned phase_regs [6][8] = '{
    '{24000, 0, 410, 7209, 62000, 3277, 3619, 14600},
    '{0, 0, 0, 18022, 0, 16384, 16384, 32768},
    '{3, 822083, 8192, 16'hB9BA, 65535, 16'hE000, 0, 0},
    '{65535, 4000, 1234, 16'h8000, 30000, 8000, 32767, 65535},
    '{40, 2000, 300, 0, 50000, 12000, 9000, 20000},
    '{120, 30000, 5000, 16000, 1000, 0, 8000, 16384}
  };

  modulated_feedback_delay_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: clearing pass plus every request at its slowest, many times over
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // Receiver: switch between always ready, random stalls and mostly stalled;
  // a long hold-off request overrides the pattern for a fixed stretch.
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 400;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(10, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Check every accepted output
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(out_sample);
  end

  task automatic write_reg(int idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx[CfgIdxW-1:0];
    cfg_data <= val[CfgDataW-1:0];
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_phase(int p);
    for (int r = 0; r < 8; r++) write_reg(r, phase_regs[p][r]);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected output, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted; gaps between bursts
  task automatic send_sample(logic signed [23:0] v);
    in_valid <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [23:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 4000)) - 2000);
      default: return r[23:0];
    endcase
  endfunction

  initial begin
    logic signed [23:0] directed [20] = '{
      24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001,
      24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh400000,
      24'shC00000, 24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh800000,
      24'sh000000, 24'sh123456, 24'shEDCBA9, 24'sh7FFFFF, 24'sh800000
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // defaults first: a directed burst of full-scale and edge-case inputs
    foreach (directed[k]) send_sample(directed[k]);
    drain();

    for (int p = 1; p < 6; p++) begin
      load_phase(p);
      // extremes of the register set get a directed burst of full scale too
      if (p <= 3) foreach (directed[k]) send_sample(directed[k]);
      for (int k = 0; k < 260; k++) begin
        if (p == 2 && k == 50) hold_req <= 1'b1;
        if (p == 2 && k == 51) hold_req <= 1'b0;
        send_sample(pick_sample());
      end
      drain();
    end

    // one last random setting within the stated ranges
    write_reg(RegDelay, $urandom_range(0, 300));
    write_reg(RegModDep, $urandom_range(0, 822083));
    write_reg(RegLfoStep, $urandom_range(0, 8192));
    write_reg(RegFbGain, 32'(int'($urandom_range(0, 36044)) - 18022));
    write_reg(RegTone, $urandom_range(0, 65535));
    write_reg(RegLowMix, 32'(int'($urandom_range(0, 24576)) - 8192));
    write_reg(RegWet, $urandom_range(0, 16384));
    write_reg(RegDry, $urandom_range(0, 32768));
    cfg_we <= 1'b0;
    for (int k = 0; k < 60; k++) send_sample(pick_sample());
    drain();
    repeat (60) @(posedge clk);

    $display("covered %0d samples over seven register settings, %0d outputs checked",
             sent, sb.checked);
    $display("including limiter overload, saturation, long output stall and leftovers=%0d",
             sb.expected_out.size());
    if (sb.mismatches == 0 && sb.expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
